### rtl/rpc_pkg.sv
// Package for the R-peak counter: payload structs, queue entry, constants.
// No dependencies; imported by every module of the block.
`timescale 1ns / 1ps
package rpc_pkg;

  localparam int MAX_RECORD_LEN = 65536;
  localparam int IDX_W = $clog2(MAX_RECORD_LEN);
  localparam int POS_W = $clog2(MAX_RECORD_LEN + 1);
  localparam int SMP_W = 16;
  localparam int WIN_W = 16;
  localparam int CNT_W = 16;
  localparam int SUM_W = ((IDX_W > WIN_W) ? IDX_W : WIN_W) + 1;

  localparam int QDEPTH = 2;
  localparam int QPTR_W = $clog2(QDEPTH);
  localparam int QCNT_W = $clog2(QDEPTH + 1);

  localparam int PADDR_W = 3;
  localparam int PDATA_W = 32;
  localparam logic [PADDR_W-3:0] REG_GAP_WIN = '0;

  typedef struct packed {
    logic signed [SMP_W-1:0] sample;
    logic                    last_sample;
  } in_t;

  typedef struct packed {
    logic             prev_is_peak;
    logic             final_is_peak;
    logic [CNT_W-1:0] peak_total;
    logic             record_done;
  } out_t;

  // Classified beat handed from front to back.
  typedef struct packed {
    logic             prev_cand;
    logic             final_cand;
    logic [IDX_W-1:0] prev_idx;
    logic [IDX_W-1:0] final_idx;
    logic             last;
  } cand_t;

endpackage

### rtl/rpc_front.sv
// Front end: magnitude, neighbor compare and sample indexing per input beat.
// Depends on rpc_pkg.
`timescale 1ns / 1ps
module rpc_front import rpc_pkg::*; (
  input  logic  clk_i,
  input  logic  rst_ni,
  input  logic  in_valid_i,
  output logic  in_ready_o,
  input  in_t   in_data_i,
  output logic  push_o,
  output cand_t push_data_o,
  input  logic  q_full_i
);

  logic [SMP_W-1:0] prev_mag_q, prev_mag_d;
  logic [SMP_W-1:0] older_mag_q, older_mag_d;
  logic [POS_W-1:0] pos_q, pos_d;
  logic [SMP_W-1:0] mag;
  logic [POS_W-1:0] pos_m1;
  logic             take;

  assign in_ready_o = !q_full_i;
  assign take       = in_valid_i && !q_full_i;
  assign push_o     = take;

  always_comb begin
    mag    = in_data_i.sample[SMP_W-1] ? (SMP_W'(0) - SMP_W'(in_data_i.sample))
                                       : SMP_W'(in_data_i.sample);
    pos_m1 = pos_q - POS_W'(1);

    push_data_o.last      = in_data_i.last_sample;
    push_data_o.prev_idx  = pos_m1[IDX_W-1:0];
    push_data_o.final_idx = (pos_q == POS_W'(MAX_RECORD_LEN)) ? IDX_W'(MAX_RECORD_LEN - 1)
                                                               : pos_q[IDX_W-1:0];
    if (pos_q == POS_W'(1)) begin
      push_data_o.prev_cand = prev_mag_q > mag;
    end else if (pos_q > POS_W'(1)) begin
      push_data_o.prev_cand = (prev_mag_q > older_mag_q) && (prev_mag_q > mag);
    end else begin
      push_data_o.prev_cand = 1'b0;
    end
    push_data_o.final_cand = in_data_i.last_sample && (pos_q != '0) && (mag > prev_mag_q);

    prev_mag_d  = prev_mag_q;
    older_mag_d = older_mag_q;
    pos_d       = pos_q;
    if (take) begin
      if (in_data_i.last_sample) begin
        prev_mag_d  = '0;
        older_mag_d = '0;
        pos_d       = '0;
      end else begin
        older_mag_d = prev_mag_q;
        prev_mag_d  = mag;
        if (pos_q != POS_W'(MAX_RECORD_LEN)) begin
          pos_d = pos_q + POS_W'(1);
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      prev_mag_q  <= '0;
      older_mag_q <= '0;
      pos_q       <= '0;
    end else begin
      prev_mag_q  <= prev_mag_d;
      older_mag_q <= older_mag_d;
      pos_q       <= pos_d;
    end
  end

endmodule

### rtl/rpc_queue.sv
// Two-entry queue of classified beats between front and back.
// Depends on rpc_pkg.
`timescale 1ns / 1ps
module rpc_queue import rpc_pkg::*; (
  input  logic  clk_i,
  input  logic  rst_ni,
  input  logic  push_i,
  input  cand_t push_data_i,
  output logic  full_o,
  input  logic  pop_i,
  output logic  valid_o,
  output cand_t pop_data_o
);

  cand_t             mem_q [QDEPTH];
  logic [QPTR_W-1:0] wptr_q, wptr_d;
  logic [QPTR_W-1:0] rptr_q, rptr_d;
  logic [QCNT_W-1:0] cnt_q, cnt_d;

  assign full_o     = cnt_q == QCNT_W'(QDEPTH);
  assign valid_o    = cnt_q != '0;
  assign pop_data_o = mem_q[rptr_q];

  always_comb begin
    wptr_d = wptr_q;
    rptr_d = rptr_q;
    cnt_d  = cnt_q;
    if (push_i) begin
      wptr_d = (wptr_q == QPTR_W'(QDEPTH - 1)) ? '0 : wptr_q + QPTR_W'(1);
    end
    if (pop_i) begin
      rptr_d = (rptr_q == QPTR_W'(QDEPTH - 1)) ? '0 : rptr_q + QPTR_W'(1);
    end
    case ({push_i, pop_i})
      2'b10:   cnt_d = cnt_q + QCNT_W'(1);
      2'b01:   cnt_d = cnt_q - QCNT_W'(1);
      default: cnt_d = cnt_q;
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wptr_q] <= push_data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q <= '0;
      rptr_q <= '0;
      cnt_q  <= '0;
    end else begin
      wptr_q <= wptr_d;
      rptr_q <= rptr_d;
      cnt_q  <= cnt_d;
    end
  end

endmodule

### rtl/rpc_back.sv
// Back end: refractory window test, saturating peak count, output register.
// Depends on rpc_pkg.
`timescale 1ns / 1ps
module rpc_back import rpc_pkg::*; (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic [WIN_W-1:0] gap_win_i,
  input  logic             q_valid_i,
  input  cand_t            q_data_i,
  output logic             pop_o,
  output logic             out_valid_o,
  input  logic             out_ready_i,
  output out_t             out_data_o
);

  logic [IDX_W-1:0] acc_q, acc_d;
  logic             any_q, any_d;
  logic [CNT_W-1:0] tot_q, tot_d;
  logic             out_valid_q, out_valid_d;
  out_t             out_q, out_d;

  logic             a1, a2, any1;
  logic [IDX_W-1:0] acc1, acc2;
  logic [CNT_W-1:0] tot1, tot2;
  logic [SUM_W-1:0] lim0, lim1;

  assign pop_o       = q_valid_i && (!out_valid_q || out_ready_i);
  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  always_comb begin
    // previous sample is judged first, the final one against the updated state
    lim0 = SUM_W'(acc_q) + SUM_W'(gap_win_i) + SUM_W'(1);
    a1   = q_data_i.prev_cand && (!any_q || SUM_W'(q_data_i.prev_idx) >= lim0);
    acc1 = a1 ? q_data_i.prev_idx : acc_q;
    any1 = any_q || a1;
    tot1 = (a1 && tot_q != '1) ? tot_q + CNT_W'(1) : tot_q;

    lim1 = SUM_W'(acc1) + SUM_W'(gap_win_i) + SUM_W'(1);
    a2   = q_data_i.final_cand && (!any1 || SUM_W'(q_data_i.final_idx) >= lim1);
    acc2 = a2 ? q_data_i.final_idx : acc1;
    tot2 = (a2 && tot1 != '1) ? tot1 + CNT_W'(1) : tot1;

    acc_d       = acc_q;
    any_d       = any_q;
    tot_d       = tot_q;
    out_d       = out_q;
    out_valid_d = out_valid_q;
    if (out_valid_q && out_ready_i) begin
      out_valid_d = 1'b0;
    end
    if (pop_o) begin
      out_valid_d         = 1'b1;
      out_d.prev_is_peak  = a1;
      out_d.final_is_peak = a2;
      out_d.peak_total    = tot2;
      out_d.record_done   = q_data_i.last;
      if (q_data_i.last) begin
        acc_d = '0;
        any_d = 1'b0;
        tot_d = '0;
      end else begin
        acc_d = acc2;
        any_d = any1 || a2;
        tot_d = tot2;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    out_q <= out_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      acc_q       <= '0;
      any_q       <= 1'b0;
      tot_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      acc_q       <= acc_d;
      any_q       <= any_d;
      tot_q       <= tot_d;
      out_valid_q <= out_valid_d;
    end
  end

endmodule

### rtl/r_peak_counter_unit.sv
// R-peak counter top: APB register, front end, queue, back end.
// Depends on rpc_pkg, rpc_front, rpc_queue, rpc_back.
// Path: an input beat is written into the queue, then taken into the output register.
// Throughput: one beat per cycle while out_ready_i is held high; the two-entry queue decouples input and output stalls.
// Reset: asynchronous, active low; clears the window register, record state, queue and
// output valid.
`timescale 1ns / 1ps
module r_peak_counter_unit import rpc_pkg::*; (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  in_t                in_data_i,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output out_t               out_data_o,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [PADDR_W-1:0] paddr,
  input  logic [PDATA_W-1:0] pwdata,
  output logic [PDATA_W-1:0] prdata,
  output logic               pready
);

  logic [WIN_W-1:0] gap_win_q;
  logic             push, pop, q_full, q_valid;
  cand_t            push_data, pop_data;
  logic             reg_hit;

  assign pready  = 1'b1;
  assign reg_hit = paddr[PADDR_W-1:2] == REG_GAP_WIN;
  assign prdata  = reg_hit ? PDATA_W'(gap_win_q) : '0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      gap_win_q <= '0;
    end else if (psel && penable && pwrite && pready && reg_hit) begin
      gap_win_q <= pwdata[WIN_W-1:0];
    end
  end

  rpc_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .in_data_i   (in_data_i),
    .push_o      (push),
    .push_data_o (push_data),
    .q_full_i    (q_full)
  );

  rpc_queue u_queue (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push),
    .push_data_i (push_data),
    .full_o      (q_full),
    .pop_i       (pop),
    .valid_o     (q_valid),
    .pop_data_o  (pop_data)
  );

  rpc_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .gap_win_i   (gap_win_q),
    .q_valid_i   (q_valid),
    .q_data_i    (pop_data),
    .pop_o       (pop),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_data_o  (out_data_o)
  );

endmodule

### rtl/rpc_checker.sv
// Port-level checker for r_peak_counter_unit, bound to the top level.
// Depends on rpc_pkg and r_peak_counter_unit.
`timescale 1ns / 1ps
module rpc_checker import rpc_pkg::*; (
  input logic               clk_i,
  input logic               rst_ni,
  input logic               in_valid_i,
  input logic               in_ready_o,
  input in_t                in_data_i,
  input logic               out_valid_o,
  input logic               out_ready_i,
  input out_t               out_data_o,
  input logic               psel,
  input logic               penable,
  input logic               pwrite,
  input logic [PADDR_W-1:0] paddr,
  input logic [PDATA_W-1:0] pwdata,
  input logic [PDATA_W-1:0] prdata,
  input logic               pready
);

  a_in_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_ready_o |=> in_valid_i && $stable(in_data_i))
    else $error("input beat changed while waiting");

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(out_data_o))
    else $error("output beat changed while stalled");

  a_final_only_on_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_data_o.final_is_peak |-> out_data_o.record_done)
    else $error("final peak flagged on a non-final beat");

  a_peak_counted: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (out_data_o.prev_is_peak || out_data_o.final_is_peak)
      |-> out_data_o.peak_total != '0)
    else $error("peak reported with zero total");

  a_window_readback: assert property (@(posedge clk_i) disable iff (!rst_ni)
    psel && penable && pwrite && pready && paddr[PADDR_W-1:2] == REG_GAP_WIN
      |=> prdata[WIN_W-1:0] == $past(pwdata[WIN_W-1:0]) || paddr[PADDR_W-1:2] != REG_GAP_WIN)
    else $error("window readback mismatch");

endmodule

bind r_peak_counter_unit rpc_checker u_rpc_checker (.*);
